// ===== hw/rtl/range_average_to_segments_macros.svh =====
// Assertion macros used by the range filter controller
`ifndef RANGE_AVERAGE_TO_SEGMENTS_MACROS_SVH
`define RANGE_AVERAGE_TO_SEGMENTS_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset
`define RATS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the standard clk_i / rst_ni pair
`define RATS_ASSERT(lbl, prop, msg) \
  `RATS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hw/rtl/rats_pkg.sv =====
// Shared types and constants of the range average to segments block
package rats_pkg;

  localparam int unsigned WindowDef   = 5;
  localparam int unsigned CountW      = 16;
  localparam int unsigned DistW       = 14;
  localparam int unsigned SegW        = 7;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned TicksReset  = 117;
  localparam int unsigned MaxReset    = 200;
  localparam int unsigned DisplayMax  = 9999;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_CM = 1'b0,
    CFG_MAX_DISTANCE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load_item;
    logic div_step;
    logic write_ring;
    logic sum_step;
    logic start_avg;
    logic cap_load;
    logic bcd_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sum_done;
    logic bcd_done;
  } status_t;

endpackage

// ===== hw/rtl/range_average_to_segments.sv =====
// Range average to segments: echo count to capped moving average with 7-segment digits
// Both divisions use the shared divider, one quotient bit per cycle.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: ticks_per_cm 117, max_distance 200, ring empty (contents undefined), no item held.
module range_average_to_segments #(
  parameter int unsigned WINDOW = rats_pkg::WindowDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rats_pkg::CountW-1:0]    echo_count_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rats_pkg::DistW-1:0]     shown_distance_o,
  output logic [rats_pkg::SegW-1:0]      seg_thousands_o,
  output logic [rats_pkg::SegW-1:0]      seg_hundreds_o,
  output logic [rats_pkg::SegW-1:0]      seg_tens_o,
  output logic [rats_pkg::SegW-1:0]      seg_ones_o,
  input  logic                           cfg_we_i,
  input  logic [rats_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rats_pkg::CfgDataW-1:0]  cfg_data_i
);

  rats_pkg::cmd_t    cmd;
  rats_pkg::status_t status;

  rats_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  rats_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .echo_count_i     (echo_count_i),
    .shown_distance_o (shown_distance_o),
    .seg_thousands_o  (seg_thousands_o),
    .seg_hundreds_o   (seg_hundreds_o),
    .seg_tens_o       (seg_tens_o),
    .seg_ones_o       (seg_ones_o)
  );

endmodule

// ===== hw/rtl/rats_dp.sv =====
// Datapath: config registers, shared divider, sample ring, sum, BCD and segment decode
module rats_dp #(
  parameter int unsigned WINDOW = rats_pkg::WindowDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rats_pkg::cmd_t                 cmd_i,
  output rats_pkg::status_t              status_o,
  input  logic                           cfg_we_i,
  input  logic [rats_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rats_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [rats_pkg::CountW-1:0]    echo_count_i,
  output logic [rats_pkg::DistW-1:0]     shown_distance_o,
  output logic [rats_pkg::SegW-1:0]      seg_thousands_o,
  output logic [rats_pkg::SegW-1:0]      seg_hundreds_o,
  output logic [rats_pkg::SegW-1:0]      seg_tens_o,
  output logic [rats_pkg::SegW-1:0]      seg_ones_o
);

  localparam int unsigned AddrW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned SumW  = rats_pkg::CountW + CntW;
  localparam int unsigned DcW   = $clog2(SumW + 1);
  localparam int unsigned CW    = rats_pkg::CountW;
  localparam int unsigned DW    = rats_pkg::DistW;
  localparam int unsigned BcdW  = 16;
  localparam int unsigned BcdCW = $clog2(DW + 1);

  function automatic logic [rats_pkg::SegW-1:0] seg_of(input logic [3:0] digit);
    logic [rats_pkg::SegW-1:0] pat;
    unique case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = '0;
    endcase
    return pat;
  endfunction

  logic [CW-1:0]    ticks_q;
  logic [DW-1:0]    max_q;

  logic [SumW-1:0]  dvd_q;
  logic [CW-1:0]    rem_q;
  logic [CW-1:0]    dvs_q;
  logic [DcW-1:0]   div_cnt_q;

  logic [CW-1:0]    ring_q [WINDOW];
  logic [AddrW-1:0] slot_q;
  logic             full_q;
  logic [CntW-1:0]  n_q;
  logic [CntW-1:0]  idx_q;
  logic [CW-1:0]    rd_data_q;
  logic             rd_vld_q;
  logic [SumW-1:0]  acc_q;

  logic [DW-1:0]    avg_q;
  logic [DW-1:0]    bin_q;
  logic [BcdW-1:0]  bcd_q;
  logic [BcdCW-1:0] bcd_cnt_q;

  logic [DW-1:0]             shown_q;
  logic [rats_pkg::SegW-1:0] seg_th_q, seg_hu_q, seg_te_q, seg_on_q;

  logic [CW:0]      rem_sh;
  logic [CW:0]      rem_diff;
  logic             q_bit;
  logic [DW-1:0]    cap_lim;
  logic [BcdW-1:0]  bcd_adj;
  logic             rd_hit;

  always_comb begin
    rem_sh   = {rem_q, dvd_q[SumW-1]};
    rem_diff = rem_sh - {1'b0, dvs_q};
    q_bit    = (rem_sh >= {1'b0, dvs_q});
    cap_lim  = (max_q > DW'(rats_pkg::DisplayMax)) ? DW'(rats_pkg::DisplayMax) : max_q;
    rd_hit   = (idx_q < n_q);
    for (int k = 0; k < 4; k++) begin
      bcd_adj[k*4 +: 4] = (bcd_q[k*4 +: 4] >= 4'd5) ? bcd_q[k*4 +: 4] + 4'd3 : bcd_q[k*4 +: 4];
    end
  end

  assign status_o.div_done = (div_cnt_q == DcW'(SumW));
  assign status_o.sum_done = !rd_hit && !rd_vld_q;
  assign status_o.bcd_done = (bcd_cnt_q == BcdCW'(DW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= CW'(rats_pkg::TicksReset);
      max_q   <= DW'(rats_pkg::MaxReset);
    end else if (cfg_we_i) begin
      unique case (rats_pkg::cfg_reg_e'(cfg_index_i))
        rats_pkg::CFG_TICKS_PER_CM: ticks_q <= cfg_data_i;
        rats_pkg::CFG_MAX_DISTANCE: max_q   <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      full_q   <= 1'b0;
      n_q      <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.write_ring) begin
      slot_q   <= (slot_q == AddrW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      if (slot_q == AddrW'(WINDOW - 1)) begin
        full_q <= 1'b1;
      end
      n_q      <= (full_q || slot_q == AddrW'(WINDOW - 1)) ? CntW'(WINDOW)
                                                            : CntW'(slot_q) + 1'b1;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else if (cmd_i.sum_step) begin
      rd_vld_q <= rd_hit;
      if (rd_hit) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_ring) begin
      ring_q[slot_q] <= dvd_q[CW-1:0];
    end
    if (cmd_i.sum_step && rd_hit) begin
      rd_data_q <= ring_q[idx_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_ring) begin
      acc_q <= '0;
    end else if (cmd_i.sum_step && rd_vld_q) begin
      acc_q <= acc_q + SumW'(rd_data_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.load_item || cmd_i.start_avg) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      dvd_q <= SumW'(echo_count_i);
      rem_q <= '0;
      dvs_q <= (ticks_q == '0) ? CW'(1) : ticks_q;
    end else if (cmd_i.start_avg) begin
      dvd_q <= acc_q;
      rem_q <= '0;
      dvs_q <= CW'(n_q);
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[SumW-2:0], q_bit};
      rem_q <= q_bit ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_cnt_q <= '0;
    end else if (cmd_i.cap_load) begin
      bcd_cnt_q <= '0;
    end else if (cmd_i.bcd_step) begin
      bcd_cnt_q <= bcd_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_load) begin
      avg_q <= (dvd_q > SumW'(cap_lim)) ? cap_lim : dvd_q[DW-1:0];
      bin_q <= (dvd_q > SumW'(cap_lim)) ? cap_lim : dvd_q[DW-1:0];
      bcd_q <= '0;
    end else if (cmd_i.bcd_step) begin
      bcd_q <= {bcd_adj[BcdW-2:0], bin_q[DW-1]};
      bin_q <= {bin_q[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      shown_q  <= avg_q;
      seg_th_q <= (bcd_q[15:12] != 4'd0) ? seg_of(bcd_q[15:12]) : '0;
      seg_hu_q <= (bcd_q[15:8] != 8'd0) ? seg_of(bcd_q[11:8]) : '0;
      seg_te_q <= (bcd_q[15:4] != 12'd0) ? seg_of(bcd_q[7:4]) : '0;
      seg_on_q <= seg_of(bcd_q[3:0]);
    end
  end

  assign shown_distance_o = shown_q;
  assign seg_thousands_o  = seg_th_q;
  assign seg_hundreds_o   = seg_hu_q;
  assign seg_tens_o       = seg_te_q;
  assign seg_ones_o       = seg_on_q;

endmodule

// ===== hw/rtl/rats_ctrl.sv =====
// Controller: sequences divide, ring update, sum, average, BCD and output handshake
`include "range_average_to_segments_macros.svh"

module rats_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rats_pkg::cmd_t    cmd_o,
  input  rats_pkg::status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_DIST,
    ST_SUM,
    ST_DIV_AVG,
    ST_BCD,
    ST_PUBLISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  rats_pkg::cmd_t cmd;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          state_d       = ST_DIV_DIST;
        end
      end
      ST_DIV_DIST: begin
        if (status_i.div_done) begin
          cmd.write_ring = 1'b1;
          state_d        = ST_SUM;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SUM: begin
        if (status_i.sum_done) begin
          cmd.start_avg = 1'b1;
          state_d       = ST_DIV_AVG;
        end else begin
          cmd.sum_step = 1'b1;
        end
      end
      ST_DIV_AVG: begin
        if (status_i.div_done) begin
          cmd.cap_load = 1'b1;
          state_d      = ST_BCD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_BCD: begin
        if (status_i.bcd_done) begin
          state_d = ST_PUBLISH;
        end else begin
          cmd.bcd_step = 1'b1;
        end
      end
      ST_PUBLISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.publish = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `RATS_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  `RATS_ASSERT(a_publish_free, cmd.publish |-> (!out_valid_q || !out_stall_i), "publish overwrites pending item")
  `RATS_ASSERT(a_publish_valid, cmd.publish |=> out_valid_q, "published item not presented")
  `RATS_ASSERT(a_accept_start, (in_valid_i && !in_stall_o) |=> (state_q == ST_DIV_DIST), "accepted item not started")

endmodule
